### design/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

    localparam int CW_WIDTH    = 38;  // codeword field width
    localparam int LEN_WIDTH   = 6;
    localparam int DATA_BITS   = 32;  // data_value / decoded_value width
    localparam int POS_COUNT   = 63;  // positions a 6-bit length can name
    localparam int CHECK_SLOTS = 6;   // check positions 1, 2, 4, .. 32
    localparam int DATA_SLOTS  = POS_COUNT - CHECK_SLOTS;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [1:0] STATUS_BEYOND    = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [DATA_BITS-1:0] data_value;
        logic [CW_WIDTH-1:0]  codeword;
        logic [LEN_WIDTH-1:0] code_length;
    } req_t;

    typedef struct packed {
        logic [CW_WIDTH-1:0]  codeword;
        logic [LEN_WIDTH-1:0] length;
        logic [DATA_BITS-1:0] decoded;
        logic [LEN_WIDTH-1:0] syndrome;
        logic [1:0]           status;
    } result_t;

    // One-based position of the j-th data slot (positions that are not powers of two)
    function automatic int data_pos(input int j);
        int cnt;
        int pos;
        cnt = -1;
        pos = 0;
        for (int p = 1; p <= POS_COUNT; p++) begin
            if ((p & (p - 1)) != 0) begin
                cnt = cnt + 1;
                if (cnt == j) begin
                    pos = p;
                end
            end
        end
        return pos;
    endfunction

    // Codeword bits covered by check bit 2^b
    function automatic logic [CW_WIDTH-1:0] cover_mask(input int b);
        logic [CW_WIDTH-1:0] mask;
        mask = '0;
        for (int q = 1; q <= CW_WIDTH; q++) begin
            if ((q & (1 << b)) != 0) begin
                mask[q-1] = 1'b1;
            end
        end
        return mask;
    endfunction

    // Fewest check bits k with 2^k >= m + k + 1
    function automatic logic [2:0] check_bits(input logic [LEN_WIDTH-1:0] m);
        logic [2:0] k;
        k = 3'd7;
        for (int kk = CHECK_SLOTS; kk >= 0; kk--) begin
            if ((1 << kk) >= (int'(m) + kk + 1)) begin
                k = 3'(kk);
            end
        end
        return k;
    endfunction

endpackage

### design/hsc_encoder.sv
`timescale 1ns / 1ps

module hsc_encoder #(
    parameter int DATA_WIDTH = 32
) (
    input  logic [hsc_pkg::DATA_BITS-1:0] value,
    output hsc_pkg::result_t              result
);
    import hsc_pkg::*;

    localparam int KeepBits = (DATA_WIDTH < DATA_BITS) ? DATA_WIDTH : DATA_BITS;
    localparam logic [DATA_BITS-1:0] KeepMask = DATA_BITS'((64'd1 << KeepBits) - 64'd1);

    logic [DATA_BITS-1:0] val;
    logic [DATA_BITS-1:0] rev;
    logic [DATA_BITS-1:0] aligned;
    logic [LEN_WIDTH-1:0] msb_count;
    logic [2:0]           check_count;
    logic [CW_WIDTH-1:0]  data_word;
    logic [CW_WIDTH-1:0]  full_word;

    always_comb
    begin
        val = value & KeepMask;
        msb_count = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            if (val[i]) begin
                msb_count = LEN_WIDTH'(i + 1);
            end
        end
        for (int i = 0; i < DATA_BITS; i++) begin
            rev[i] = val[DATA_BITS-1-i];
        end
        // put the top significant bit in data slot 0
        aligned = rev >> (LEN_WIDTH'(DATA_BITS) - msb_count);
        data_word = '0;
        for (int j = 0; j < DATA_BITS; j++) begin
            data_word[data_pos(j)-1] = aligned[j];
        end
        full_word = data_word;
        for (int b = 0; b < CHECK_SLOTS; b++) begin
            full_word[(1 << b) - 1] = ^(data_word & cover_mask(b));
        end
        check_count = check_bits(msb_count);
    end

    always_comb
    begin
        result.codeword = full_word;
        result.length   = msb_count + LEN_WIDTH'(check_count);
        result.decoded  = '0;
        result.syndrome = '0;
        result.status   = STATUS_OK;
    end

endmodule

### design/hsc_decoder.sv
`timescale 1ns / 1ps

module hsc_decoder (
    input  logic [hsc_pkg::CW_WIDTH-1:0]  codeword,
    input  logic [hsc_pkg::LEN_WIDTH-1:0] code_length,
    output hsc_pkg::result_t              result
);
    import hsc_pkg::*;

    logic [POS_COUNT-1:0]  len_mask;
    logic [POS_COUNT-1:0]  word;
    logic [POS_COUNT-1:0]  fixed;
    logic [LEN_WIDTH-1:0]  syn;
    logic                  hit;
    logic [DATA_SLOTS-1:0] slots;
    logic [LEN_WIDTH-1:0]  pow_count;
    logic [LEN_WIDTH-1:0]  data_count;

    always_comb
    begin
        len_mask = {POS_COUNT{1'b1}} >> (LEN_WIDTH'(POS_COUNT) - code_length);
        word = POS_COUNT'(codeword) & len_mask;
        for (int b = 0; b < CHECK_SLOTS; b++) begin
            syn[b] = ^(word[CW_WIDTH-1:0] & cover_mask(b));
        end
        hit = (syn != '0) && (syn <= code_length);
        // a flip may land above the field width when the length says so
        fixed = word;
        if (hit) begin
            fixed = word ^ (POS_COUNT'(1) << (syn - LEN_WIDTH'(1)));
        end
        for (int j = 0; j < DATA_SLOTS; j++) begin
            slots[DATA_SLOTS-1-j] = fixed[data_pos(j)-1];
        end
        pow_count = '0;
        for (int b = 0; b < CHECK_SLOTS; b++) begin
            pow_count = pow_count + LEN_WIDTH'(code_length >= LEN_WIDTH'(1 << b));
        end
        data_count = code_length - pow_count;
    end

    always_comb
    begin
        result.codeword = fixed[CW_WIDTH-1:0];
        result.length   = code_length;
        // keep the low word of the data read MSB first
        result.decoded  = DATA_BITS'(slots >> (LEN_WIDTH'(DATA_SLOTS) - data_count));
        result.syndrome = syn;
        if (syn == '0) begin
            result.status = STATUS_OK;
        end else if (hit) begin
            result.status = STATUS_CORRECTED;
        end else begin
            result.status = STATUS_BEYOND;
        end
    end

endmodule

### design/hamming_sec_codec_variable_length.sv
`timescale 1ns / 1ps

// Hamming single-error-correcting codec with a codeword length that follows
// the value. Words enter on the req channel (req_valid/req_ready) and leave on
// the rsp channel (rsp_valid/rsp_ready); a word moves when valid and ready are
// both high at a rising edge.
// command selects encode (data_value in, codeword_out and length_out back) or
// correct-and-decode (codeword and code_length in, corrected word, data,
// syndrome and status back).
// An accepted word is held in the input register and then loaded into the result
// register when that is free or being read; rsp_valid rises with that load.
// Throughput: one word per cycle while rsp_ready does not hold the result register;
// the encoder and decoder are single-pass logic between the input and result registers.
// A stalled rsp_ready holds the result register; the input register still
// takes one more word, and req_ready drops only when both are full.
// Reset (rst_n low) empties both registers; no words are held afterwards.
// DATA_WIDTH limits how many low bits of data_value are encoded.
module hamming_sec_codec_variable_length #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          command,
    input  logic [hsc_pkg::DATA_BITS-1:0] data_value,
    input  logic [hsc_pkg::CW_WIDTH-1:0]  codeword,
    input  logic [hsc_pkg::LEN_WIDTH-1:0] code_length,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [hsc_pkg::CW_WIDTH-1:0]  codeword_out,
    output logic [hsc_pkg::LEN_WIDTH-1:0] length_out,
    output logic [hsc_pkg::DATA_BITS-1:0] decoded_value,
    output logic [hsc_pkg::LEN_WIDTH-1:0] error_position,
    output logic [1:0]                    status
);
    import hsc_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    req_t    in_word_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_word_reg;
    logic    out_load;
    logic    req_take;
    result_t enc_result;
    result_t dec_result;
    result_t sel_result;

    hsc_encoder #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_encoder (
        .value (in_word_reg.data_value),
        .result(enc_result)
    );

    hsc_decoder u_decoder (
        .codeword   (in_word_reg.codeword),
        .code_length(in_word_reg.code_length),
        .result     (dec_result)
    );

    always_comb
    begin
        out_load  = in_valid_reg && (!out_valid_reg || rsp_ready);
        req_ready = !in_valid_reg || out_load;
        req_take  = req_valid && req_ready;

        in_valid_next = in_valid_reg;
        if (req_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (rsp_ready) begin
            out_valid_next = 1'b0;
        end

        sel_result = (in_word_reg.command == CMD_DECODE) ? dec_result : enc_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take) begin
            in_word_reg.command     <= command;
            in_word_reg.data_value  <= data_value;
            in_word_reg.codeword    <= codeword;
            in_word_reg.code_length <= code_length;
        end
        if (out_load) begin
            out_word_reg <= sel_result;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign codeword_out   = out_word_reg.codeword;
    assign length_out     = out_word_reg.length;
    assign decoded_value  = out_word_reg.decoded;
    assign error_position = out_word_reg.syndrome;
    assign status         = out_word_reg.status;

    // a loaded word must show up on the result side
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp_valid)
        else $error("loaded word missing from result register");

    // a free input register never blocks the request side
    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> req_ready)
        else $error("req_ready low with empty input register");

    a_corrected_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == STATUS_CORRECTED) |->
            (error_position != '0 && error_position <= length_out))
        else $error("corrected position outside codeword");

    a_beyond_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == STATUS_BEYOND) |-> (error_position > length_out))
        else $error("beyond status with syndrome inside codeword");

    a_clean_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((status == STATUS_OK) == (error_position == '0)))
        else $error("status disagrees with syndrome");

endmodule

### sim/tb_hamming_sec_codec_variable_length.sv
`timescale 1ns / 1ps

module tb_hamming_sec_codec_variable_length;

    import hsc_pkg::*;

    localparam int TB_DATA_WIDTH  = 32;
    localparam int RANDOM_WORDS   = 1500;
    localparam int PHASE_WORDS    = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROW_COUNT      = 16;

    typedef struct {
        logic                 cmd;
        logic [DATA_BITS-1:0] value;
        logic [CW_WIDTH-1:0]  word;
        logic [LEN_WIDTH-1:0] len;
        bit                   typed;
        result_t              res;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic                 command = CMD_ENCODE;
    logic [DATA_BITS-1:0] data_value = '0;
    logic [CW_WIDTH-1:0]  codeword = '0;
    logic [LEN_WIDTH-1:0] code_length = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [CW_WIDTH-1:0]  codeword_out;
    logic [LEN_WIDTH-1:0] length_out;
    logic [DATA_BITS-1:0] decoded_value;
    logic [LEN_WIDTH-1:0] error_position;
    logic [1:0]           status;

    result_t offered_result = '0;
    result_t pending_results[$];
    int      err_count = 0;
    int      idle_cycles = 0;
    int      sender_idle_pct = 0;
    int      recv_stall_pct = 0;

    stim_row_t directed_rows[ROW_COUNT] = '{
        // zero value gives an empty word; ignored decode fields set
        '{CMD_ENCODE, 32'd0, {CW_WIDTH{1'b1}}, 6'd63, 1'b1,
          '{38'd0, 6'd0, 32'd0, 6'd0, STATUS_OK}},
        '{CMD_ENCODE, 32'd1, 38'd0, 6'd0, 1'b1,
          '{38'd7, 6'd3, 32'd0, 6'd0, STATUS_OK}},
        '{CMD_ENCODE, 32'hFFFF_FFFF, 38'd0, 6'd0, 1'b0, '0},
        '{CMD_ENCODE, 32'h8000_0000, 38'h15_5555_5555, 6'd21, 1'b0, '0},
        '{CMD_ENCODE, 32'h5A5A_5A5A, 38'd0, 6'd0, 1'b0, '0},
        '{CMD_DECODE, 32'hFFFF_FFFF, 38'd7, 6'd3, 1'b1,
          '{38'd7, 6'd3, 32'd1, 6'd0, STATUS_OK}},
        // single flipped bit at position 3
        '{CMD_DECODE, 32'd0, 38'd3, 6'd3, 1'b1,
          '{38'd7, 6'd3, 32'd1, 6'd3, STATUS_CORRECTED}},
        // syndrome points past the word
        '{CMD_DECODE, 32'd0, 38'd3, 6'd2, 1'b1,
          '{38'd3, 6'd2, 32'd0, 6'd3, STATUS_BEYOND}},
        '{CMD_DECODE, 32'd0, 38'd0, 6'd0, 1'b1,
          '{38'd0, 6'd0, 32'd0, 6'd0, STATUS_OK}},
        '{CMD_DECODE, 32'd0, {CW_WIDTH{1'b1}}, 6'd0, 1'b1,
          '{38'd0, 6'd0, 32'd0, 6'd0, STATUS_OK}},
        '{CMD_DECODE, 32'd0, {CW_WIDTH{1'b1}}, 6'd38, 1'b0, '0},
        '{CMD_DECODE, 32'd0, {CW_WIDTH{1'b1}}, 6'd63, 1'b0, '0},
        '{CMD_DECODE, 32'd0, {CW_WIDTH{1'b1}}, 6'd5, 1'b0, '0},
        // syndrome 63: flip lands above the field, inside a long length
        '{CMD_DECODE, 32'd0, 38'hC000_0000, 6'd63, 1'b0, '0},
        '{CMD_DECODE, 32'd0, 38'hC000_0000, 6'd40, 1'b0, '0},
        '{CMD_DECODE, 32'h1234_5678, 38'h2A_AAAA_AAAA, 6'd39, 1'b0, '0}
    };

    hamming_sec_codec_variable_length #(
        .DATA_WIDTH(TB_DATA_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .command       (command),
        .data_value    (data_value),
        .codeword      (codeword),
        .code_length   (code_length),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .codeword_out  (codeword_out),
        .length_out    (length_out),
        .decoded_value (decoded_value),
        .error_position(error_position),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t codec_result(input logic cmd, input logic [DATA_BITS-1:0] value,
                                             input logic [CW_WIDTH-1:0] word_in,
                                             input logic [LEN_WIDTH-1:0] len_in);
        result_t              res;
        logic [63:0]          val;
        logic [63:0]          word;
        logic [DATA_BITS-1:0] dec;
        logic [1:0]           stat;
        int                   m;
        int                   k;
        int                   n;
        int                   di;
        int                   syn;
        bit                   par;
        word = '0;
        dec  = '0;
        syn  = 0;
        stat = STATUS_OK;
        if (cmd == CMD_ENCODE)
        begin
            val = 64'(value);
            if (TB_DATA_WIDTH < 64)
                val &= (64'd1 << TB_DATA_WIDTH) - 64'd1;
            m = 0;
            while (m < 64 && (val >> m) != 0)
                m++;
            k = 0;
            while ((64'd1 << k) < 64'(m + k + 1))
                k++;
            n  = m + k;
            di = m;
            // data bits MSB first into the non-check positions
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    di--;
                    word[p-1] = val[di];
                end
            end
            for (int p = 1; p <= n; p = p << 1)
            begin
                par = 1'b0;
                for (int q = 1; q <= n; q++)
                    if ((q & p) != 0)
                        par ^= word[q-1];
                word[p-1] = par;
            end
        end
        else
        begin
            n    = int'(len_in);
            word = 64'(word_in) & ((64'd1 << n) - 64'd1);
            for (int p = 1; p <= n; p++)
                if (word[p-1])
                    syn ^= p;
            if (syn != 0)
            begin
                if (syn <= n)
                begin
                    word[syn-1] = ~word[syn-1];
                    stat = STATUS_CORRECTED;
                end
                else
                    stat = STATUS_BEYOND;
            end
            for (int p = 1; p <= n; p++)
                if ((p & (p - 1)) != 0)
                    dec = {dec[DATA_BITS-2:0], word[p-1]};
        end
        res.codeword = word[CW_WIDTH-1:0];
        res.length   = LEN_WIDTH'(n);
        res.decoded  = dec;
        res.syndrome = LEN_WIDTH'(syn);
        res.status   = stat;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            err_count++;
        end
    endtask

    // Offer one word; hold valid and payload until it is taken.
    task automatic offer_word(input logic cmd, input logic [DATA_BITS-1:0] value,
                              input logic [CW_WIDTH-1:0] word, input logic [LEN_WIDTH-1:0] len,
                              input result_t res);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        command        <= cmd;
        data_value     <= value;
        codeword       <= word;
        code_length    <= len;
        offered_result <= res;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                pending_results.push_back(offered_result);
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: codeword_out 0x%0h", codeword_out);
                    err_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    compare_field("codeword_out", 64'(exp_res.codeword), 64'(codeword_out));
                    compare_field("length_out", 64'(exp_res.length), 64'(length_out));
                    compare_field("decoded_value", 64'(exp_res.decoded), 64'(decoded_value));
                    compare_field("error_position", 64'(exp_res.syndrome),
                                  64'(error_position));
                    compare_field("status", 64'(exp_res.status), 64'(status));
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        result_t              res;
        logic                 cmd;
        logic [DATA_BITS-1:0] value;
        logic [CW_WIDTH-1:0]  word;
        logic [LEN_WIDTH-1:0] len;
        int                   m;
        int                   pick;
        int                   pos_a;
        int                   pos_b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            res = directed_rows[i].typed ? directed_rows[i].res :
                  codec_result(directed_rows[i].cmd, directed_rows[i].value,
                               directed_rows[i].word, directed_rows[i].len);
            offer_word(directed_rows[i].cmd, directed_rows[i].value,
                       directed_rows[i].word, directed_rows[i].len, res);
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % PHASE_WORDS == 0)
            begin
                case ((i / PHASE_WORDS) % 4)
                    0:
                    begin
                        sender_idle_pct = 0;
                        recv_stall_pct <= 0;
                    end
                    1:
                    begin
                        sender_idle_pct = 51;
                        recv_stall_pct <= 0;
                    end
                    2:
                    begin
                        sender_idle_pct = 0;
                        recv_stall_pct <= 51;
                    end
                    default:
                    begin
                        sender_idle_pct = 15;
                        recv_stall_pct <= 15;
                    end
                endcase
            end
            // value of random bit length, top bit set
            m = $urandom_range(DATA_BITS, 0);
            value = (m == 0) ? '0 :
                    ((DATA_BITS'($urandom) & (DATA_BITS'({DATA_BITS{1'b1}}) >> (DATA_BITS - m)))
                     | (DATA_BITS'(1) << (m - 1)));
            word = CW_WIDTH'({$urandom, $urandom});
            len  = LEN_WIDTH'($urandom);
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                cmd   = CMD_ENCODE;
                value = ($urandom_range(9) == 0) ? DATA_BITS'($urandom) : value;
            end
            else if (pick < 85)
            begin
                // valid codeword with zero, one or two flipped bits
                cmd  = CMD_DECODE;
                res  = codec_result(CMD_ENCODE, value, '0, '0);
                word = res.codeword;
                len  = res.length;
                pick = $urandom_range(9);
                if (len != 0 && pick >= 3)
                begin
                    pos_a = $urandom_range(int'(len) - 1);
                    word[pos_a] = ~word[pos_a];
                    if (pick == 9 && len > 1)
                    begin
                        pos_b = (pos_a + $urandom_range(int'(len) - 1, 1)) % int'(len);
                        word[pos_b] = ~word[pos_b];
                    end
                end
                value = DATA_BITS'($urandom);
            end
            else
            begin
                cmd = CMD_DECODE;
                if ($urandom_range(1) == 0)
                    len = LEN_WIDTH'($urandom_range(CW_WIDTH));
            end
            offer_word(cmd, value, word, len, codec_result(cmd, value, word, len));
        end

        req_valid      <= 1'b0;
        recv_stall_pct <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
